@@ design/braking_distance_velocity_clamp_defines.svh @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ---------------------------------------------------------------------------
`ifndef BRAKING_DISTANCE_VELOCITY_CLAMP_DEFINES_SVH
`define BRAKING_DISTANCE_VELOCITY_CLAMP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define BDVC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("braking clamp assertion failed");

// Next-cycle implication, disabled during reset.
`define BDVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("braking clamp assertion failed");

`else

`define BDVC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDVC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/bdvc_pkg.sv @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp package
// Field widths, register indexes, reset values and the item record.
// ---------------------------------------------------------------------------
`default_nettype none

package bdvc_pkg;

   localparam int VEL_W     = 16;
   localparam int DIST_W    = 16;
   localparam int CFG_W     = 16;
   localparam int SPEED_W   = 15;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DIST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_ACCEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SPEED  = 2'd2;

   localparam logic [CFG_W-1:0]   STOP_DIST_RESET   = 16'd20;
   localparam logic [CFG_W-1:0]   BRAKE_ACCEL_RESET = 16'd1000;
   localparam logic [SPEED_W-1:0] FULL_SPEED_RESET  = 15'd3000;

   // Command and sensor flags that ride along the pipeline with each item.
   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] rot_z;
      logic                    front_online;
      logic                    left_online;
      logic                    front_stop;
      logic                    left_stop;
   } item_type;

endpackage

`default_nettype wire

@@ design/bdvc_intf.sv @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp channel interfaces
// Request, response and register write channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdvc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bdvc_pkg::VEL_W-1:0]    vel_x;
   logic signed [bdvc_pkg::VEL_W-1:0]    vel_y;
   logic signed [bdvc_pkg::VEL_W-1:0]    rot_z;
   logic        [bdvc_pkg::DIST_W-1:0]   front_distance_cm;
   logic        [bdvc_pkg::DIST_W-1:0]   left_distance_cm;
   logic                                 front_online;
   logic                                 left_online;

   modport source (output valid, vel_x, vel_y, rot_z, front_distance_cm,
                   left_distance_cm, front_online, left_online, input ready);
   modport sink   (input valid, vel_x, vel_y, rot_z, front_distance_cm,
                   left_distance_cm, front_online, left_online, output ready);
endinterface

interface bdvc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bdvc_pkg::VEL_W-1:0]    limited_x;
   logic signed [bdvc_pkg::VEL_W-1:0]    limited_y;
   logic signed [bdvc_pkg::VEL_W-1:0]    rot_out;
   logic                                 fwd_clamped;
   logic                                 fwd_stopped;
   logic                                 side_clamped;
   logic                                 side_stopped;
   logic                                 fwd_no_link;
   logic                                 side_no_link;

   modport source (output valid, limited_x, limited_y, rot_out, fwd_clamped,
                   fwd_stopped, side_clamped, side_stopped, fwd_no_link,
                   side_no_link, input ready);
   modport sink   (input valid, limited_x, limited_y, rot_out, fwd_clamped,
                   fwd_stopped, side_clamped, side_stopped, fwd_no_link,
                   side_no_link, output ready);
endinterface

interface bdvc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [bdvc_pkg::CSR_IDX_W-1:0]       index;
   logic [bdvc_pkg::CFG_W-1:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/bdvc_prep.sv @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp radicand front end
// Three stages: margin and stop test, accel times margin, constant scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module bdvc_prep #(
   parameter int CM_TO_MM = 10,
   parameter int RAD_W    = 37
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  wire                            in_valid,
   input  bdvc_pkg::item_type             in_item,
   input  wire [bdvc_pkg::DIST_W-1:0]     front_dist,
   input  wire [bdvc_pkg::DIST_W-1:0]     left_dist,
   input  wire [bdvc_pkg::CFG_W-1:0]      stop_dist,
   input  wire [bdvc_pkg::CFG_W-1:0]      brake_accel,
   output logic                           out_valid,
   output bdvc_pkg::item_type             out_item,
   output logic [1:0][RAD_W-1:0]          out_rad
);
   import bdvc_pkg::*;

   localparam int PROD_W = DIST_W + CFG_W;
   localparam int SCALE  = 2 * CM_TO_MM;

   logic                     a_valid_ff, b_valid_ff, c_valid_ff;
   item_type                 a_item_ff, b_item_ff, c_item_ff;
   item_type                 a_item_in;
   logic [1:0][DIST_W-1:0]   a_margin_ff, a_margin_in;
   logic [1:0][PROD_W-1:0]   b_prod_ff, b_prod_in;
   logic [1:0][RAD_W-1:0]    c_rad_ff, c_rad_in;
   logic                     front_stop, left_stop;

   // Stage A: margin over the stop distance, zero when inside it.
   always_comb begin
      front_stop             = (front_dist <= stop_dist);
      left_stop              = (left_dist <= stop_dist);
      a_item_in              = in_item;
      a_item_in.front_stop   = front_stop;
      a_item_in.left_stop    = left_stop;
      a_margin_in[0]         = front_stop ? '0 : front_dist - stop_dist;
      a_margin_in[1]         = left_stop ? '0 : left_dist - stop_dist;
   end

   // Stage B: deceleration times margin, Stage C: times twice the unit scale.
   always_comb begin
      for (int lane = 0; lane < 2; lane++) begin
         b_prod_in[lane] = PROD_W'(a_margin_ff[lane]) * PROD_W'(brake_accel);
         c_rad_in[lane]  = RAD_W'(b_prod_ff[lane]) * RAD_W'(SCALE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff   <= a_item_in;
         a_margin_ff <= a_margin_in;
         b_item_ff   <= a_item_ff;
         b_prod_ff   <= b_prod_in;
         c_item_ff   <= b_item_ff;
         c_rad_ff    <= c_rad_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_item  = c_item_ff;
   assign out_rad   = c_rad_ff;

endmodule

`default_nettype wire

@@ design/bdvc_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp square root cell
// One restoring root digit for the front and left lanes per cell.
// ---------------------------------------------------------------------------
`default_nettype none

module bdvc_sqrt_cell #(
   parameter int SQ_W = 19
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  wire                            in_valid,
   input  bdvc_pkg::item_type             in_item,
   input  wire [1:0][2*SQ_W-1:0]          in_rad,
   input  wire [1:0][SQ_W+1:0]            in_rem,
   input  wire [1:0][SQ_W-1:0]            in_root,
   output logic                           out_valid,
   output bdvc_pkg::item_type             out_item,
   output logic [1:0][2*SQ_W-1:0]         out_rad,
   output logic [1:0][SQ_W+1:0]           out_rem,
   output logic [1:0][SQ_W-1:0]           out_root
);
   import bdvc_pkg::*;

   logic                     valid_ff;
   item_type                 item_ff;
   logic [1:0][2*SQ_W-1:0]   rad_ff, rad_in;
   logic [1:0][SQ_W+1:0]     rem_ff, rem_in;
   logic [1:0][SQ_W-1:0]     root_ff, root_in;
   logic [1:0][SQ_W+1:0]     rem_shift, trial;
   logic [1:0]               take;

   // Bring down the next two radicand bits and try the digit one.
   always_comb begin
      for (int lane = 0; lane < 2; lane++) begin
         rem_shift[lane] = {in_rem[lane][SQ_W-1:0], in_rad[lane][2*SQ_W-1 -: 2]};
         trial[lane]     = {in_root[lane], 2'b01};
         take[lane]      = (rem_shift[lane] >= trial[lane]);
         rem_in[lane]    = take[lane] ? rem_shift[lane] - trial[lane] : rem_shift[lane];
         root_in[lane]   = {in_root[lane][SQ_W-2:0], take[lane]};
         rad_in[lane]    = {in_rad[lane][2*SQ_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= in_item;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

`default_nettype wire

@@ design/braking_distance_velocity_clamp.sv @@
// Pipeline: three radicand stages, one cell per root bit in the square root
// chain, one output register.
// Throughput: one item per cycle; the whole chain halts while a result waits.
// Reset clears all pipeline valid bits and loads the register reset values.
// Register writes are taken in any cycle, ready is always high.
// ---------------------------------------------------------------------------
// Braking distance velocity clamp
// Limits forward and leftward speed to what the braking distance allows.
// ---------------------------------------------------------------------------
`default_nettype none
`include "braking_distance_velocity_clamp_defines.svh"

module braking_distance_velocity_clamp #(
   parameter int CM_TO_MM = 10
) (
   input  wire        clock,
   input  wire        reset,
   bdvc_req_if.sink   req_ch,
   bdvc_rsp_if.source rsp_ch,
   bdvc_csr_if.sink   csr_ch
);
   import bdvc_pkg::*;

   localparam int RAD_W  = 33 + $clog2(CM_TO_MM + 1);
   localparam int SQ_W   = (RAD_W + 1) / 2;
   localparam int RADP_W = 2 * SQ_W;
   localparam int CMP_W  = SQ_W + 1;

   // Configuration registers.
   logic [CFG_W-1:0]   stop_dist_ff;
   logic [CFG_W-1:0]   brake_accel_ff;
   logic [SPEED_W-1:0] full_speed_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_dist_ff   <= STOP_DIST_RESET;
         brake_accel_ff <= BRAKE_ACCEL_RESET;
         full_speed_ff  <= FULL_SPEED_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_STOP_DIST:   stop_dist_ff   <= csr_ch.data;
            CSR_BRAKE_ACCEL: brake_accel_ff <= csr_ch.data;
            CSR_FULL_SPEED:  full_speed_ff  <= csr_ch.data[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves unless a result is held at the output.
   logic out_valid_ff;
   logic advance;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   item_type req_item;

   always_comb begin
      req_item              = '0;
      req_item.vel_x        = req_ch.vel_x;
      req_item.vel_y        = req_ch.vel_y;
      req_item.rot_z        = req_ch.rot_z;
      req_item.front_online = req_ch.front_online;
      req_item.left_online  = req_ch.left_online;
   end

   // Radicand front end.
   logic                   prep_valid;
   item_type               prep_item;
   logic [1:0][RAD_W-1:0]  prep_rad;

   bdvc_prep #(
      .CM_TO_MM (CM_TO_MM),
      .RAD_W    (RAD_W)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_ch.valid),
      .in_item     (req_item),
      .front_dist  (req_ch.front_distance_cm),
      .left_dist   (req_ch.left_distance_cm),
      .stop_dist   (stop_dist_ff),
      .brake_accel (brake_accel_ff),
      .out_valid   (prep_valid),
      .out_item    (prep_item),
      .out_rad     (prep_rad)
   );

   // Square root chain, one cell per root bit.
   logic                     cell_valid [SQ_W+1];
   item_type                 cell_item  [SQ_W+1];
   logic [1:0][RADP_W-1:0]   cell_rad   [SQ_W+1];
   logic [1:0][SQ_W+1:0]     cell_rem   [SQ_W+1];
   logic [1:0][SQ_W-1:0]     cell_root  [SQ_W+1];

   assign cell_valid[0]  = prep_valid;
   assign cell_item[0]   = prep_item;
   assign cell_rad[0][0] = RADP_W'(prep_rad[0]);
   assign cell_rad[0][1] = RADP_W'(prep_rad[1]);
   assign cell_rem[0]    = '0;
   assign cell_root[0]   = '0;

   for (genvar k = 0; k < SQ_W; k++) begin : g_cell
      bdvc_sqrt_cell #(
         .SQ_W (SQ_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[k]),
         .in_item   (cell_item[k]),
         .in_rad    (cell_rad[k]),
         .in_rem    (cell_rem[k]),
         .in_root   (cell_root[k]),
         .out_valid (cell_valid[k+1]),
         .out_item  (cell_item[k+1]),
         .out_rad   (cell_rad[k+1]),
         .out_rem   (cell_rem[k+1]),
         .out_root  (cell_root[k+1])
      );
   end

   // Limit compare and clamp on the finished roots.
   item_type           fin_item;
   logic [SQ_W-1:0]    lim_f, lim_l;
   logic               unl_f, unl_l;
   logic               clamp_f, clamp_l;
   logic [16:0]        mag_x;
   logic [VEL_W-1:0]   lim_l16;
   logic signed [VEL_W-1:0] ox_in, oy_in;

   always_comb begin
      fin_item = cell_item[SQ_W];
      lim_f    = fin_item.front_stop ? '0 : cell_root[SQ_W][0];
      lim_l    = fin_item.left_stop ? '0 : cell_root[SQ_W][1];
      unl_f    = !fin_item.front_stop && (cell_root[SQ_W][0] >= SQ_W'(full_speed_ff));
      unl_l    = !fin_item.left_stop && (cell_root[SQ_W][1] >= SQ_W'(full_speed_ff));
      mag_x    = 17'(0) - {fin_item.vel_x[VEL_W-1], fin_item.vel_x};
      clamp_f  = fin_item.front_online && !unl_f && !fin_item.vel_y[VEL_W-1]
                 && (CMP_W'(fin_item.vel_y[VEL_W-2:0]) > CMP_W'(lim_f));
      clamp_l  = fin_item.left_online && !unl_l && fin_item.vel_x[VEL_W-1]
                 && (CMP_W'(mag_x) > CMP_W'(lim_l));
      lim_l16  = VEL_W'(lim_l);
      oy_in    = clamp_f ? $signed(VEL_W'(lim_f)) : fin_item.vel_y;
      ox_in    = clamp_l ? $signed(VEL_W'(0) - lim_l16) : fin_item.vel_x;
   end

   // Output register.
   logic signed [VEL_W-1:0] ox_ff, oy_ff, rot_ff;
   logic                    f_lim_ff, f_blk_ff, l_lim_ff, l_blk_ff, f_off_ff, l_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= cell_valid[SQ_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         rot_ff   <= fin_item.rot_z;
         f_lim_ff <= clamp_f;
         f_blk_ff <= clamp_f && (lim_f == '0);
         l_lim_ff <= clamp_l;
         l_blk_ff <= clamp_l && (lim_l == '0);
         f_off_ff <= !fin_item.front_online;
         l_off_ff <= !fin_item.left_online;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.limited_x    = ox_ff;
   assign rsp_ch.limited_y    = oy_ff;
   assign rsp_ch.rot_out      = rot_ff;
   assign rsp_ch.fwd_clamped  = f_lim_ff;
   assign rsp_ch.fwd_stopped  = f_blk_ff;
   assign rsp_ch.side_clamped = l_lim_ff;
   assign rsp_ch.side_stopped = l_blk_ff;
   assign rsp_ch.fwd_no_link  = f_off_ff;
   assign rsp_ch.side_no_link = l_off_ff;

   // Conditions checked on the registered result.
   logic                     fwd_stop_ok, side_stop_ok, link_ok, rsp_stall;
   logic [2*VEL_W-1:0]       held_xy;

   assign fwd_stop_ok  = f_lim_ff && (oy_ff == '0);
   assign side_stop_ok = l_lim_ff && (ox_ff == '0);
   assign link_ok      = !(f_off_ff && f_lim_ff) && !(l_off_ff && l_lim_ff);
   assign rsp_stall    = out_valid_ff && !rsp_ch.ready;
   assign held_xy      = {ox_ff, oy_ff};

   // Blocked results are clamps to zero, and offline sensors never clamp.
   `BDVC_ASSERT_IMPL(a_fwd_stop, clock, reset, out_valid_ff && f_blk_ff, fwd_stop_ok)
   `BDVC_ASSERT_IMPL(a_side_stop, clock, reset, out_valid_ff && l_blk_ff, side_stop_ok)
   `BDVC_ASSERT_IMPL(a_link_free, clock, reset, out_valid_ff, link_ok)
   // A held result keeps its clamped values while the chain is halted.
   `BDVC_ASSERT_NEXT(a_hold_result, clock, reset, rsp_stall, $stable(held_xy) && out_valid_ff)

endmodule

`default_nettype wire

@@ verif/braking_distance_velocity_clamp_tb.sv @@
// ---------------------------------------------------------------------------
// Braking distance velocity clamp testbench
// Drives velocity commands with range readings into the clamp, predicts the
// clamped command and status flags from its own braking model, and compares
// every result field by field. The register settings cover the extremes, and
// both sides insert random idle cycles. A long output stall fills the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module braking_distance_velocity_clamp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdvc_pkg::*;

   localparam int CM_TO_MM      = 10;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_GAP       = 6;
   localparam int SWEEP_PHASES  = 26;
   localparam int PHASE_ITEMS   = 71;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRESSURE_ITEMS = 80;
   localparam int PRINT_LIMIT   = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One velocity command with its sensor readings.
   typedef struct {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] rot_z;
      logic [DIST_W-1:0]       front_distance_cm;
      logic [DIST_W-1:0]       left_distance_cm;
      logic                    front_online;
      logic                    left_online;
   } command_type;

   // One clamped command with its status flags.
   typedef struct {
      logic signed [VEL_W-1:0] limited_x;
      logic signed [VEL_W-1:0] limited_y;
      logic signed [VEL_W-1:0] rot_out;
      logic                    fwd_clamped;
      logic                    fwd_stopped;
      logic                    side_clamped;
      logic                    side_stopped;
      logic                    fwd_no_link;
      logic                    side_no_link;
   } clamp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdvc_req_if req_if ();
   bdvc_rsp_if rsp_if ();
   bdvc_csr_if csr_if ();

   braking_distance_velocity_clamp i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Shadow copies of the configuration registers.
   logic [CFG_W-1:0]   stop_dist_cm = STOP_DIST_RESET;
   logic [CFG_W-1:0]   brake_accel  = BRAKE_ACCEL_RESET;
   logic [SPEED_W-1:0] full_speed   = FULL_SPEED_RESET;

   clamp_result_type pending_clamps[$];
   int mismatch_count  = 0;
   bit pace_idle       = 1'b1;
   int rsp_hold_cycles = 0;

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Exact integer floor square root, one result bit at a time.
   function automatic longint unsigned floor_root(input longint unsigned radicand);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root;
   endfunction

   // Allowed speed for one reading; unlimited when the root reaches full speed.
   function automatic void speed_limit(input logic [DIST_W-1:0] dist_cm,
                                       output bit unlimited, output int limit);
      longint unsigned margin;
      longint unsigned radicand;
      longint unsigned root;
      unlimited = 1'b0;
      limit     = 0;
      if (dist_cm > stop_dist_cm) begin
         margin   = 64'(dist_cm) - 64'(stop_dist_cm);
         radicand = 64'd2 * 64'(brake_accel) * margin * 64'(CM_TO_MM);
         root     = floor_root(radicand);
         if (root >= 64'(full_speed)) unlimited = 1'b1;
         else limit = int'(root);
      end
   endfunction

   // Expected clamped command for one accepted item.
   function automatic clamp_result_type predict_clamp(input command_type cmd);
      clamp_result_type res;
      bit unlimited;
      int limit;
      int vx;
      int vy;
      vx = int'(cmd.vel_x);
      vy = int'(cmd.vel_y);
      res.limited_x    = cmd.vel_x;
      res.limited_y    = cmd.vel_y;
      res.rot_out      = cmd.rot_z;
      res.fwd_clamped  = 1'b0;
      res.fwd_stopped  = 1'b0;
      res.side_clamped = 1'b0;
      res.side_stopped = 1'b0;
      res.fwd_no_link  = !cmd.front_online;
      res.side_no_link = !cmd.left_online;
      // Only forward motion is limited by the front reading.
      if (cmd.front_online) begin
         speed_limit(cmd.front_distance_cm, unlimited, limit);
         if (!unlimited && vy > 0 && vy > limit) begin
            res.limited_y   = VEL_W'(limit);
            res.fwd_clamped = 1'b1;
            res.fwd_stopped = (limit == 0);
         end
      end
      // Only leftward motion is limited by the left reading.
      if (cmd.left_online) begin
         speed_limit(cmd.left_distance_cm, unlimited, limit);
         if (!unlimited && vx < 0 && -vx > limit) begin
            res.limited_x    = VEL_W'(-limit);
            res.side_clamped = 1'b1;
            res.side_stopped = (limit == 0);
         end
      end
      return res;
   endfunction

   function automatic command_type make_command(
         input logic signed [VEL_W-1:0] vx, input logic signed [VEL_W-1:0] vy,
         input logic signed [VEL_W-1:0] rz, input logic [DIST_W-1:0] fwd_reading,
         input logic [DIST_W-1:0] side_reading, input logic front_on,
         input logic left_on);
      command_type cmd;
      cmd.vel_x             = vx;
      cmd.vel_y             = vy;
      cmd.rot_z             = rz;
      cmd.front_distance_cm = fwd_reading;
      cmd.left_distance_cm  = side_reading;
      cmd.front_online      = front_on;
      cmd.left_online       = left_on;
      return cmd;
   endfunction

   // Speeds mostly around the current full speed, where clamping decisions flip.
   function automatic logic signed [VEL_W-1:0] pick_speed();
      int span;
      span = int'(full_speed) + 100;
      if (span > 32767) span = 32767;
      case ($urandom_range(0, 7))
         0, 1: return VEL_W'($urandom);
         7: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               default: return -16'sd1;
            endcase
         end
         default: return VEL_W'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   // Distances near the stop distance and near the knee where the limit ends.
   function automatic logic [DIST_W-1:0] pick_distance();
      longint knee;
      longint dist_val;
      if (brake_accel == 0) knee = 0;
      else knee = (longint'(full_speed) * full_speed) / (2 * CM_TO_MM * longint'(brake_accel));
      case ($urandom_range(0, 9))
         0, 1, 2: dist_val = longint'($urandom_range(0, 65535));
         3, 4:    dist_val = longint'(stop_dist_cm) + int'($urandom_range(0, 6)) - 3;
         5, 6, 7: dist_val = longint'(stop_dist_cm) + knee + int'($urandom_range(0, 10)) - 5;
         8:       dist_val = $urandom_range(0, 1) ? longint'(65535) : longint'(0);
         default: dist_val = longint'(stop_dist_cm) + int'($urandom_range(0, 400));
      endcase
      if (dist_val < 0) dist_val = 0;
      else if (dist_val > 65535) dist_val = 65535;
      return dist_val[DIST_W-1:0];
   endfunction

   function automatic command_type random_command();
      return make_command(pick_speed(), pick_speed(), VEL_W'($urandom), pick_distance(),
                          pick_distance(), $urandom_range(0, 4) != 0,
                          $urandom_range(0, 4) != 0);
   endfunction

   function automatic logic [CFG_W-1:0] pick_register_value(
         input logic [CSR_IDX_W-1:0] reg_index);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         4: return CFG_W'($urandom);
         default: begin
            case (reg_index)
               CSR_STOP_DIST:   return CFG_W'($urandom_range(0, 300));
               CSR_BRAKE_ACCEL: return CFG_W'($urandom_range(1, 20000));
               default:         return CFG_W'($urandom_range(1, 6000));
            endcase
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [VEL_W-1:0] got,
                              input logic [VEL_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("%s got %b, expected %b", name, got, want));
   endtask

   // Sends one item, after a random gap when idle pacing is on, and records its expected result.
   task automatic send_command(input command_type cmd);
      int gap;
      gap = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.vel_x             <= cmd.vel_x;
      req_if.vel_y             <= cmd.vel_y;
      req_if.rot_z             <= cmd.rot_z;
      req_if.front_distance_cm <= cmd.front_distance_cm;
      req_if.left_distance_cm  <= cmd.left_distance_cm;
      req_if.front_online      <= cmd.front_online;
      req_if.left_online       <= cmd.left_online;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      pending_clamps.push_back(predict_clamp(cmd));
   endtask

   // Writes one register once every outstanding result has come back.
   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [CFG_W-1:0] data);
      req_if.valid <= 1'b0;
      while (pending_clamps.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= reg_index;
      csr_if.data  <= data;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (reg_index)
         CSR_STOP_DIST:   stop_dist_cm = data;
         CSR_BRAKE_ACCEL: brake_accel  = data;
         CSR_FULL_SPEED:  full_speed   = data[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   // Reset settings: blocked, limited, unlimited, offline and reverse motion.
   task automatic test_reset_defaults();
      send_command(make_command(-16'sd32768, 16'sd32767, -16'sd32768, 0, 0, 1, 1));
      send_command(make_command(-16'sd1, 16'sd1, 0, 20, 20, 1, 1));
      send_command(make_command(-16'sd141, 16'sd142, 0, 21, 21, 1, 1));
      send_command(make_command(-16'sd32768, 16'sd32767, 0, 469, 470, 1, 1));
      send_command(make_command(-16'sd32768, 16'sd32767, 16'sd32767, 65535, 65535, 1, 1));
      send_command(make_command(-16'sd32768, 16'sd32767, 16'sh5555, 0, 0, 0, 0));
      send_command(make_command(16'sd32767, -16'sd32768, 16'shAAAA, 0, 0, 1, 1));
      send_command(make_command(0, 0, 0, 0, 0, 1, 1));
      send_command(make_command(-16'sd5000, 16'sd5000, 0, 100, 0, 1, 0));
      send_command(make_command(-16'sd5000, 16'sd5000, 0, 0, 100, 0, 1));
   endtask

   // Register corners: unused index, zero acceleration, zero full speed, maxima.
   task automatic test_register_corners();
      write_register(CSR_UNUSED, 16'hFFFF);
      send_command(make_command(0, 16'sd142, 0, 21, 21, 1, 1));
      write_register(CSR_BRAKE_ACCEL, 16'd0);
      send_command(make_command(-16'sd1, 16'sd1, 0, 100, 100, 1, 1));
      write_register(CSR_FULL_SPEED, 16'd0);
      send_command(make_command(-16'sd32768, 16'sd32767, 0, 100, 100, 1, 1));
      send_command(make_command(-16'sd5, 16'sd5, 0, 20, 20, 1, 1));
      write_register(CSR_STOP_DIST, 16'hFFFF);
      write_register(CSR_BRAKE_ACCEL, 16'hFFFF);
      write_register(CSR_FULL_SPEED, 16'hFFFF);
      send_command(make_command(-16'sd1, 16'sd1, 0, 65535, 65535, 1, 1));
      write_register(CSR_STOP_DIST, 16'd0);
      send_command(make_command(-16'sd32768, 16'sd32767, 0, 1, 0, 1, 1));
      send_command(make_command(-16'sd32768, 16'sd32767, 0, 65535, 65535, 1, 1));
      // The top bit of the full speed write is dropped, leaving zero.
      write_register(CSR_FULL_SPEED, 16'h8000);
      send_command(make_command(-16'sd100, 16'sd100, 0, 1, 1, 1, 1));
   endtask

   // Output held off for a long stretch while items keep coming.
   task automatic test_output_backpressure();
      pace_idle       = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (PRESSURE_ITEMS) send_command(random_command());
      pace_idle = 1'b1;
   endtask

   // Random items over a sequence of register settings.
   task automatic test_random_sweep();
      for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
         if (phase == 0) begin
            write_register(CSR_STOP_DIST, 16'd0);
            write_register(CSR_BRAKE_ACCEL, 16'hFFFF);
            write_register(CSR_FULL_SPEED, 16'h7FFF);
         end else if (phase == 1) begin
            write_register(CSR_STOP_DIST, 16'hFFFF);
            write_register(CSR_BRAKE_ACCEL, 16'd0);
            write_register(CSR_FULL_SPEED, 16'd0);
         end else if (phase == 2) begin
            write_register(CSR_STOP_DIST, STOP_DIST_RESET);
            write_register(CSR_BRAKE_ACCEL, BRAKE_ACCEL_RESET);
            write_register(CSR_FULL_SPEED, CFG_W'(FULL_SPEED_RESET));
         end else begin
            write_register(CSR_STOP_DIST, pick_register_value(CSR_STOP_DIST));
            write_register(CSR_BRAKE_ACCEL, pick_register_value(CSR_BRAKE_ACCEL));
            write_register(CSR_FULL_SPEED, pick_register_value(CSR_FULL_SPEED));
            if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, CFG_W'($urandom));
         end
         // Every fourth phase runs without idle cycles on either side.
         pace_idle = (phase % 4 != 3);
         repeat (PHASE_ITEMS) send_command(random_command());
      end
      pace_idle = 1'b1;
   endtask

   // Result side ready: a random stall before each item when idle pacing is on, plus the long hold.
   initial begin : rsp_ready_driver
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
      end
   end

   // Compares each accepted result with the oldest expected one.
   always @(posedge clock) begin : result_checker
      clamp_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_clamps.size() == 0) begin
            report_mismatch("result arrived with no command pending");
         end else begin
            want = pending_clamps.pop_front();
            check_field("limited_x", rsp_if.limited_x, want.limited_x);
            check_field("limited_y", rsp_if.limited_y, want.limited_y);
            check_field("rot_out", rsp_if.rot_out, want.rot_out);
            check_flag("fwd_clamped", rsp_if.fwd_clamped, want.fwd_clamped);
            check_flag("fwd_stopped", rsp_if.fwd_stopped, want.fwd_stopped);
            check_flag("side_clamped", rsp_if.side_clamped, want.side_clamped);
            check_flag("side_stopped", rsp_if.side_stopped, want.side_stopped);
            check_flag("fwd_no_link", rsp_if.fwd_no_link, want.fwd_no_link);
            check_flag("side_no_link", rsp_if.side_no_link, want.side_no_link);
         end
      end
   end

   initial begin : test_sequence
      req_if.valid             <= 1'b0;
      req_if.vel_x             <= '0;
      req_if.vel_y             <= '0;
      req_if.rot_z             <= '0;
      req_if.front_distance_cm <= '0;
      req_if.left_distance_cm  <= '0;
      req_if.front_online      <= 1'b0;
      req_if.left_online       <= 1'b0;
      csr_if.valid             <= 1'b0;
      csr_if.index             <= '0;
      csr_if.data              <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_output_backpressure();
      test_register_corners();
      test_random_sweep();

      // Let every outstanding result come back, then a little longer.
      req_if.valid <= 1'b0;
      while (pending_clamps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
